// ===== sv/hmlc_pkg.sv =====
// ----------------------------------------------------------------------------
// hmlc_pkg
// shared types and constants of the hot method lfu cache
// ----------------------------------------------------------------------------
package hmlc_pkg;

   localparam int CACHE_ENTRIES   = 256;
   localparam int PENDING_ENTRIES = 256;
   localparam int CIDX_W = $clog2(CACHE_ENTRIES);
   localparam int PIDX_W = $clog2(PENDING_ENTRIES);
   localparam int SCAN_W = ((CIDX_W > PIDX_W) ? CIDX_W : PIDX_W) + 1;
   localparam int OCC_W  = $clog2(CACHE_ENTRIES + 1);
   localparam int KEY_W  = 32;
   localparam int CNT_W  = 32;
   localparam int PCNT_W = 8;
   localparam int THR_W  = 8;
   localparam int SLOT_W = 8;
   localparam int OCCO_W = 9;
   localparam logic [THR_W-1:0] HOT_THRESHOLD_RESET = 8'd10;

   localparam logic [2:0] OP_INVOKE     = 3'd0;
   localparam logic [2:0] OP_COMPILE    = 3'd1;
   localparam logic [2:0] OP_OSR        = 3'd2;
   localparam logic [2:0] OP_INVALIDATE = 3'd3;
   localparam logic [2:0] OP_FLUSH      = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_COUNTED = 2'd1;
   localparam logic [1:0] ST_DROPPED = 2'd2;
   localparam logic [1:0] ST_MISS    = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] hits;
      logic [CNT_W-1:0] invokes;
      logic             osr;
   } centry_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [PCNT_W-1:0] count;
   } pentry_type;

   typedef struct packed {
      logic              wr_en;
      logic [CIDX_W-1:0] wr_addr;
      centry_type        wr_data;
      logic              clr_en;
      logic [CIDX_W-1:0] clr_addr;
      logic              clr_all;
   } cwr_type;

   typedef struct packed {
      logic              wr_en;
      logic [PIDX_W-1:0] wr_addr;
      pentry_type        wr_data;
      logic              clr_en;
      logic [PIDX_W-1:0] clr_addr;
      logic              clr_all;
   } pwr_type;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_CSCAN  = 5'b00010,
      S_PSCAN  = 5'b00100,
      S_UPDATE = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

endpackage

// ===== sv/hot_method_lfu_cache_top.sv =====
// ----------------------------------------------------------------------------
// hot_method_lfu_cache_top
// method-keyed cache with hotness threshold and least-hits eviction
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command first
// sweeps the cache memory, one slot per cycle, through the registered read
// port, finding the key, the lowest free slot and the slot with the fewest
// hits. An invoke of an uncached method then sweeps the pending memory the
// same way. The S_UPDATE state writes back, and the result appears on the
// rsp_ ports for exactly one cycle with rsp_strobe; busy drops in the cycle
// after the strobe, so a new command is only taken once the result of the
// last one is out. The receiver cannot stall; each strobe is one transfer.
// The user must write the threshold register through csr_ only while no
// command is open; the block itself does not enforce it.
module hot_method_lfu_cache_top import hmlc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic [KEY_W-1:0]   req_method_id,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic               rsp_was_cached,
   output logic               rsp_installed_now,
   output logic               rsp_evicted,
   output logic [KEY_W-1:0]   rsp_victim_method,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic [CNT_W-1:0]   rsp_invocations,
   output logic [CNT_W-1:0]   rsp_hits,
   output logic               rsp_osr_mark,
   output logic [PCNT_W-1:0]  rsp_pending_count,
   output logic [OCCO_W-1:0]  rsp_occupancy,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [THR_W-1:0]   csr_hot_threshold
);

   // control state
   state_type         state_ff, state_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [2:0]        op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;       // read address counter
   logic              cmp_vld_ff, cmp_vld_in; // read data of cmp_idx is back
   logic [SCAN_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;

   // cache sweep results
   logic              hit_ff, hit_in;
   logic [CIDX_W-1:0] hslot_ff, hslot_in;
   centry_type        hdata_ff, hdata_in;
   logic              cfree_ff, cfree_in;
   logic [CIDX_W-1:0] cfslot_ff, cfslot_in;
   logic [CNT_W-1:0]  min_hits_ff, min_hits_in;
   logic [CIDX_W-1:0] min_slot_ff, min_slot_in;
   logic [KEY_W-1:0]  min_key_ff, min_key_in;

   // pending sweep results
   logic              phit_ff, phit_in;
   logic [PIDX_W-1:0] pslot_ff, pslot_in;
   logic [PCNT_W-1:0] pcnt_ff, pcnt_in;
   logic              pfree_ff, pfree_in;
   logic [PIDX_W-1:0] pfslot_ff, pfslot_in;

   // result registers
   logic              strobe_ff, strobe_in;
   logic [1:0]        status_ff, status_in;
   logic              was_ff, was_in;
   logic              inst_ff, inst_in;
   logic              ev_ff, ev_in;
   logic [KEY_W-1:0]  victim_ff, victim_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  inv_ff, inv_in;
   logic [CNT_W-1:0]  hits_ff, hits_in;
   logic              osr_ff, osr_in;
   logic [PCNT_W-1:0] pc_ff, pc_in;

   // memory ports
   centry_type c_rd;
   logic       c_rd_valid;
   pentry_type p_rd;
   logic       p_rd_valid;
   cwr_type    cwr;
   pwr_type    pwr;

   hmlc_cache_mem u_cache (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (scan_ff[CIDX_W-1:0]),
      .rd_data  (c_rd),
      .rd_valid (c_rd_valid),
      .wr       (cwr)
   );

   hmlc_pend_mem u_pend (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (scan_ff[PIDX_W-1:0]),
      .rd_data  (p_rd),
      .rd_valid (p_rd_valid),
      .wr       (pwr)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      logic [THR_W-1:0]  thr_eff;
      logic [PCNT_W-1:0] cnt_new;
      logic              p_ok;
      logic [PIDX_W-1:0] p_sel;
      logic              do_install;
      logic [CIDX_W-1:0] islot;
      centry_type        upd;

      state_in    = state_ff;
      thr_in      = thr_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      scan_in     = scan_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = scan_ff;
      occ_in      = occ_ff;
      hit_in      = hit_ff;
      hslot_in    = hslot_ff;
      hdata_in    = hdata_ff;
      cfree_in    = cfree_ff;
      cfslot_in   = cfslot_ff;
      min_hits_in = min_hits_ff;
      min_slot_in = min_slot_ff;
      min_key_in  = min_key_ff;
      phit_in     = phit_ff;
      pslot_in    = pslot_ff;
      pcnt_in     = pcnt_ff;
      pfree_in    = pfree_ff;
      pfslot_in   = pfslot_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      was_in      = was_ff;
      inst_in     = inst_ff;
      ev_in       = ev_ff;
      victim_in   = victim_ff;
      slot_in     = slot_ff;
      inv_in      = inv_ff;
      hits_in     = hits_ff;
      osr_in      = osr_ff;
      pc_in       = pc_ff;
      cwr         = '0;
      pwr         = '0;

      thr_eff    = (thr_ff == '0) ? THR_W'(1) : thr_ff;
      cnt_new    = '0;
      p_ok       = 1'b0;
      p_sel      = '0;
      do_install = 1'b0;
      islot      = '0;
      upd        = '0;

      if (csr_valid) thr_in = csr_hot_threshold;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_operation;
               key_in   = req_method_id;
               scan_in  = '0;
               hit_in   = 1'b0;
               cfree_in = 1'b0;
               phit_in  = 1'b0;
               pfree_in = 1'b0;
               state_in = S_CSCAN;
            end
         end

         S_CSCAN: begin
            // issue reads until every slot is requested
            if (scan_ff < SCAN_W'(CACHE_ENTRIES)) begin
               scan_in    = scan_ff + SCAN_W'(1);
               cmp_vld_in = 1'b1;
            end
            if (cmp_vld_ff) begin
               if (c_rd_valid && c_rd.key == key_ff && !hit_ff) begin
                  hit_in   = 1'b1;
                  hslot_in = cmp_idx_ff[CIDX_W-1:0];
                  hdata_in = c_rd;
               end
               if (!c_rd_valid && !cfree_ff) begin
                  cfree_in  = 1'b1;
                  cfslot_in = cmp_idx_ff[CIDX_W-1:0];
               end
               // strict compare keeps the lowest slot on a tie
               if (cmp_idx_ff == '0 || c_rd.hits < min_hits_ff) begin
                  min_hits_in = c_rd.hits;
                  min_slot_in = cmp_idx_ff[CIDX_W-1:0];
                  min_key_in  = c_rd.key;
               end
               if (cmp_idx_ff == SCAN_W'(CACHE_ENTRIES - 1)) begin
                  scan_in = '0;
                  if (op_ff == OP_INVOKE && !hit_in) begin
                     state_in = S_PSCAN;
                  end else begin
                     state_in = S_UPDATE;
                  end
               end
            end
         end

         S_PSCAN: begin
            if (scan_ff < SCAN_W'(PENDING_ENTRIES)) begin
               scan_in    = scan_ff + SCAN_W'(1);
               cmp_vld_in = 1'b1;
            end
            if (cmp_vld_ff) begin
               if (p_rd_valid && p_rd.key == key_ff && !phit_ff) begin
                  phit_in  = 1'b1;
                  pslot_in = cmp_idx_ff[PIDX_W-1:0];
                  pcnt_in  = p_rd.count;
               end
               if (!p_rd_valid && !pfree_ff) begin
                  pfree_in  = 1'b1;
                  pfslot_in = cmp_idx_ff[PIDX_W-1:0];
               end
               if (cmp_idx_ff == SCAN_W'(PENDING_ENTRIES - 1)) begin
                  state_in = S_UPDATE;
               end
            end
         end

         S_UPDATE: begin
            strobe_in = 1'b1;
            status_in = ST_OK;
            was_in    = hit_ff;
            inst_in   = 1'b0;
            ev_in     = 1'b0;
            victim_in = '0;
            slot_in   = '0;
            inv_in    = '0;
            hits_in   = '0;
            osr_in    = 1'b0;
            pc_in     = '0;
            upd       = hdata_ff;
            unique case (op_ff)
               OP_INVOKE, OP_COMPILE, OP_OSR: begin
                  if (hit_ff) begin
                     if (hdata_ff.hits != '1) upd.hits = hdata_ff.hits + CNT_W'(1);
                     if (op_ff == OP_INVOKE && hdata_ff.invokes != '1) begin
                        upd.invokes = hdata_ff.invokes + CNT_W'(1);
                     end
                     if (op_ff == OP_OSR) upd.osr = 1'b1;
                     cwr.wr_en   = 1'b1;
                     cwr.wr_addr = hslot_ff;
                     cwr.wr_data = upd;
                     slot_in     = SLOT_W'(hslot_ff);
                     inv_in      = upd.invokes;
                     hits_in     = upd.hits;
                     osr_in      = upd.osr;
                  end else if (op_ff != OP_INVOKE) begin
                     do_install = 1'b1;
                  end else begin
                     // uncached invoke goes through the pending table
                     p_ok    = phit_ff || pfree_ff;
                     p_sel   = phit_ff ? pslot_ff : pfslot_ff;
                     cnt_new = phit_ff ? pcnt_ff : '0;
                     if (cnt_new != '1) cnt_new = cnt_new + PCNT_W'(1);
                     if (!p_ok) begin
                        status_in = ST_DROPPED;
                     end else if (cnt_new >= thr_eff) begin
                        pwr.clr_en   = 1'b1;
                        pwr.clr_addr = p_sel;
                        do_install   = 1'b1;
                     end else begin
                        pwr.wr_en       = 1'b1;
                        pwr.wr_addr     = p_sel;
                        pwr.wr_data.key = key_ff;
                        pwr.wr_data.count = cnt_new;
                        status_in = ST_COUNTED;
                        pc_in     = cnt_new;
                     end
                  end
                  if (do_install) begin
                     islot       = cfree_ff ? cfslot_ff : min_slot_ff;
                     upd.key     = key_ff;
                     upd.hits    = '0;
                     upd.invokes = '0;
                     upd.osr     = (op_ff == OP_OSR);
                     cwr.wr_en   = 1'b1;
                     cwr.wr_addr = islot;
                     cwr.wr_data = upd;
                     inst_in     = 1'b1;
                     ev_in       = !cfree_ff;
                     victim_in   = cfree_ff ? '0 : min_key_ff;
                     slot_in     = SLOT_W'(islot);
                     osr_in      = upd.osr;
                     if (cfree_ff) occ_in = occ_ff + OCC_W'(1);
                  end
               end
               OP_INVALIDATE: begin
                  if (hit_ff) begin
                     cwr.clr_en   = 1'b1;
                     cwr.clr_addr = hslot_ff;
                     occ_in       = occ_ff - OCC_W'(1);
                  end else begin
                     status_in = ST_MISS;
                  end
               end
               OP_FLUSH: begin
                  cwr.clr_all = 1'b1;
                  pwr.clr_all = 1'b1;
                  occ_in      = '0;
               end
               default: begin
                  // unknown code: nothing changes
               end
            endcase
            state_in = S_DONE;
         end

         S_DONE: begin
            // result strobe cycle
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         thr_ff     <= HOT_THRESHOLD_RESET;
         occ_ff     <= '0;
         strobe_ff  <= 1'b0;
         cmp_vld_ff <= 1'b0;
         scan_ff    <= '0;
         hit_ff     <= 1'b0;
         cfree_ff   <= 1'b0;
         phit_ff    <= 1'b0;
         pfree_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         thr_ff     <= thr_in;
         occ_ff     <= occ_in;
         strobe_ff  <= strobe_in;
         cmp_vld_ff <= cmp_vld_in;
         scan_ff    <= scan_in;
         hit_ff     <= hit_in;
         cfree_ff   <= cfree_in;
         phit_ff    <= phit_in;
         pfree_ff   <= pfree_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      cmp_idx_ff  <= cmp_idx_in;
      hslot_ff    <= hslot_in;
      hdata_ff    <= hdata_in;
      cfslot_ff   <= cfslot_in;
      min_hits_ff <= min_hits_in;
      min_slot_ff <= min_slot_in;
      min_key_ff  <= min_key_in;
      pslot_ff    <= pslot_in;
      pcnt_ff     <= pcnt_in;
      pfslot_ff   <= pfslot_in;
      status_ff   <= status_in;
      was_ff      <= was_in;
      inst_ff     <= inst_in;
      ev_ff       <= ev_in;
      victim_ff   <= victim_in;
      slot_ff     <= slot_in;
      inv_ff      <= inv_in;
      hits_ff     <= hits_in;
      osr_ff      <= osr_in;
      pc_ff       <= pc_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_was_cached    = was_ff;
   assign rsp_installed_now = inst_ff;
   assign rsp_evicted       = ev_ff;
   assign rsp_victim_method = victim_ff;
   assign rsp_slot          = slot_ff;
   assign rsp_invocations   = inv_ff;
   assign rsp_hits          = hits_ff;
   assign rsp_osr_mark      = osr_ff;
   assign rsp_pending_count = pc_ff;
   assign rsp_occupancy     = OCCO_W'(occ_ff);

endmodule

// ===== sv/hmlc_cache_mem.sv =====
// ----------------------------------------------------------------------------
// hmlc_cache_mem
// cache entry memory with per-slot valid flops, one read and one write port
// ----------------------------------------------------------------------------
module hmlc_cache_mem import hmlc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [CIDX_W-1:0] rd_addr,
   output centry_type        rd_data,
   output logic              rd_valid,
   input  cwr_type           wr
);

   centry_type             mem [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] valid_ff;
   centry_type             rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         mem[wr.wr_addr] <= wr.wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr.clr_all) begin
            valid_ff <= '0;
         end else begin
            if (wr.clr_en) valid_ff[wr.clr_addr] <= 1'b0;
            if (wr.wr_en)  valid_ff[wr.wr_addr]  <= 1'b1;
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// ===== sv/hmlc_pend_mem.sv =====
// ----------------------------------------------------------------------------
// hmlc_pend_mem
// pending counter memory with per-slot valid flops
// ----------------------------------------------------------------------------
module hmlc_pend_mem import hmlc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [PIDX_W-1:0] rd_addr,
   output pentry_type        rd_data,
   output logic              rd_valid,
   input  pwr_type           wr
);

   pentry_type               mem [PENDING_ENTRIES];
   logic [PENDING_ENTRIES-1:0] valid_ff;
   pentry_type               rd_data_ff;
   logic                     rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         mem[wr.wr_addr] <= wr.wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr.clr_all) begin
            valid_ff <= '0;
         end else begin
            if (wr.clr_en) valid_ff[wr.clr_addr] <= 1'b0;
            if (wr.wr_en)  valid_ff[wr.wr_addr]  <= 1'b1;
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// ===== tb/sv/hot_method_lfu_cache_top_tb.sv =====
// ----------------------------------------------------------------------------
// hot_method_lfu_cache_top_tb
// self-checking bench: commands with random gaps, responses compared field by
// field with predictions from a behavioral model of the cache and pending tables
// ----------------------------------------------------------------------------
module hot_method_lfu_cache_top_tb;
   import hmlc_pkg::*;

   // one predicted response, one field per rsp_ port other than rsp_strobe
   typedef struct {
      logic [1:0]        status;
      logic              was_cached;
      logic              installed_now;
      logic              evicted;
      logic [KEY_W-1:0]  victim;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  invocations;
      logic [CNT_W-1:0]  hits;
      logic              osr;
      logic [PCNT_W-1:0] pcount;
      logic [OCCO_W-1:0] occupancy;
   } cache_rsp_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_operation;
   logic [KEY_W-1:0]   req_method_id;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic               rsp_was_cached;
   logic               rsp_installed_now;
   logic               rsp_evicted;
   logic [KEY_W-1:0]   rsp_victim_method;
   logic [SLOT_W-1:0]  rsp_slot;
   logic [CNT_W-1:0]   rsp_invocations;
   logic [CNT_W-1:0]   rsp_hits;
   logic               rsp_osr_mark;
   logic [PCNT_W-1:0]  rsp_pending_count;
   logic [OCCO_W-1:0]  rsp_occupancy;
   logic               csr_valid;
   logic               csr_ready;
   logic [THR_W-1:0]   csr_hot_threshold;

   // shadow copy of the cache and pending tables
   logic [THR_W-1:0]  mdl_threshold;
   logic              mdl_valid    [CACHE_ENTRIES];
   logic [KEY_W-1:0]  mdl_key      [CACHE_ENTRIES];
   logic [CNT_W-1:0]  mdl_hits     [CACHE_ENTRIES];
   logic [CNT_W-1:0]  mdl_invokes  [CACHE_ENTRIES];
   logic              mdl_osr      [CACHE_ENTRIES];
   logic              mdl_pvalid   [PENDING_ENTRIES];
   logic [KEY_W-1:0]  mdl_pkey     [PENDING_ENTRIES];
   logic [PCNT_W-1:0] mdl_pcount   [PENDING_ENTRIES];
   int                mdl_total;

   cache_rsp_type expected_rsps[$];
   int          mismatches;
   int          rsp_seen;
   int          cmd_sent;
   int          installs_seen;
   int          evictions_seen;
   longint      cycle_count;
   logic [KEY_W-1:0] recent_keys[$];

   hot_method_lfu_cache_top i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog: stops the run with a failure once cycle_count passes CYCLE_LIMIT
   localparam longint CYCLE_LIMIT = 4_000_000;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic void clear_tables();
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         mdl_valid[i] = 1'b0;
         mdl_key[i] = '0; mdl_hits[i] = '0; mdl_invokes[i] = '0; mdl_osr[i] = 1'b0;
      end
      for (int i = 0; i < PENDING_ENTRIES; i++) begin
         mdl_pvalid[i] = 1'b0; mdl_pkey[i] = '0; mdl_pcount[i] = '0;
      end
      mdl_total = 0;
   endfunction

   // lowest free slot, else the least-hit slot (lowest on a tie) is evicted
   function automatic int place_method(logic [KEY_W-1:0] key, inout cache_rsp_type r);
      int s;
      s = -1;
      for (int i = 0; i < CACHE_ENTRIES; i++)
         if (!mdl_valid[i]) begin
            s = i;
            break;
         end
      if (s < 0) begin
         s = 0;
         for (int i = 1; i < CACHE_ENTRIES; i++)
            if (mdl_hits[i] < mdl_hits[s]) s = i;
         r.evicted = 1'b1;
         r.victim = mdl_key[s];
         mdl_total--;
      end
      mdl_valid[s] = 1'b1;
      mdl_key[s] = key;
      mdl_hits[s] = '0;
      mdl_invokes[s] = '0;
      mdl_osr[s] = 1'b0;
      mdl_total++;
      r.installed_now = 1'b1;
      return s;
   endfunction

   function automatic cache_rsp_type predict_command(logic [2:0] op, logic [KEY_W-1:0] key);
      cache_rsp_type r;
      int s;
      int p;
      r = '{default: '0};
      s = -1;
      for (int i = 0; i < CACHE_ENTRIES; i++)
         if (mdl_valid[i] && mdl_key[i] == key) begin
            s = i;
            break;
         end
      r.was_cached = (s >= 0);
      case (op)
         OP_INVOKE: begin
            if (s >= 0) begin
               mdl_hits[s] = sat_inc(mdl_hits[s]);
               mdl_invokes[s] = sat_inc(mdl_invokes[s]);
            end else begin
               p = -1;
               for (int i = 0; i < PENDING_ENTRIES; i++)
                  if (mdl_pvalid[i] && mdl_pkey[i] == key) begin
                     p = i;
                     break;
                  end
               if (p < 0)
                  for (int i = 0; i < PENDING_ENTRIES; i++)
                     if (!mdl_pvalid[i]) begin
                        p = i;
                        mdl_pvalid[i] = 1'b1;
                        mdl_pkey[i] = key;
                        mdl_pcount[i] = '0;
                        break;
                     end
               if (p < 0) begin
                  r.status = ST_DROPPED;
               end else begin
                  if (mdl_pcount[p] != '1) mdl_pcount[p] = mdl_pcount[p] + 1'b1;
                  // a threshold of zero acts like one
                  if (mdl_pcount[p] >= mdl_threshold) begin
                     mdl_pvalid[p] = 1'b0;
                     mdl_pcount[p] = '0;
                     s = place_method(key, r);
                  end else begin
                     r.status = ST_COUNTED;
                     r.pcount = mdl_pcount[p];
                  end
               end
            end
         end
         OP_COMPILE, OP_OSR: begin
            // a pending entry of the same key is left alone
            if (s >= 0) mdl_hits[s] = sat_inc(mdl_hits[s]);
            else s = place_method(key, r);
            if (op == OP_OSR) mdl_osr[s] = 1'b1;
         end
         OP_INVALIDATE: begin
            if (s >= 0) begin
               mdl_valid[s] = 1'b0;
               mdl_total--;
            end else begin
               r.status = ST_MISS;
            end
            s = -1;
         end
         OP_FLUSH: begin
            for (int i = 0; i < CACHE_ENTRIES; i++) mdl_valid[i] = 1'b0;
            for (int i = 0; i < PENDING_ENTRIES; i++) mdl_pvalid[i] = 1'b0;
            mdl_total = 0;
            s = -1;
         end
         default: s = -1;
      endcase
      if (s >= 0) begin
         r.slot = s[SLOT_W-1:0];
         r.invocations = mdl_invokes[s];
         r.hits = mdl_hits[s];
         r.osr = mdl_osr[s];
      end
      r.occupancy = mdl_total[OCCO_W-1:0];
      return r;
   endfunction

   // each strobe is one transfer, compared with the oldest prediction
   always @(posedge clock) begin
      cache_rsp_type e;
      if (!reset && rsp_strobe) begin
         rsp_seen++;
         if (rsp_installed_now) installs_seen++;
         if (rsp_evicted) evictions_seen++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at cycle %0d", cycle_count);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status || rsp_was_cached !== e.was_cached ||
                rsp_installed_now !== e.installed_now || rsp_evicted !== e.evicted ||
                rsp_victim_method !== e.victim || rsp_slot !== e.slot ||
                rsp_invocations !== e.invocations || rsp_hits !== e.hits ||
                rsp_osr_mark !== e.osr || rsp_pending_count !== e.pcount ||
                rsp_occupancy !== e.occupancy) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch on response %0d", rsp_seen);
                  $display({"  exp st=%0d wc=%0b in=%0b ev=%0b vic=%h sl=%0d",
                            " inv=%0d hit=%0d osr=%0b pc=%0d occ=%0d"},
                     e.status, e.was_cached, e.installed_now, e.evicted, e.victim, e.slot,
                     e.invocations, e.hits, e.osr, e.pcount, e.occupancy);
                  $display({"  got st=%0d wc=%0b in=%0b ev=%0b vic=%h sl=%0d",
                            " inv=%0d hit=%0d osr=%0b pc=%0d occ=%0d"},
                     rsp_status, rsp_was_cached, rsp_installed_now, rsp_evicted,
                     rsp_victim_method, rsp_slot, rsp_invocations, rsp_hits, rsp_osr_mark,
                     rsp_pending_count, rsp_occupancy);
               end
            end
         end
      end
   end

   // one command transfer; the gap counts idle cycles once busy has dropped
   task automatic send_command(logic [2:0] op, logic [KEY_W-1:0] key, int gap);
      @(negedge clock);
      while (busy) @(negedge clock);
      repeat (gap) @(negedge clock);
      start <= 1'b1;
      req_operation <= op;
      req_method_id <= key;
      do @(posedge clock); while (busy);
      expected_rsps.push_back(predict_command(op, key));
      cmd_sent++;
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic drain_responses();
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] value);
      drain_responses();
      csr_valid <= 1'b1;
      csr_hot_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      mdl_threshold = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // keys mostly from a small recently used set so hits and installs happen
   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] k;
      if (recent_keys.size() != 0 && $urandom_range(0, 3) != 0)
         return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      k = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 63);
      recent_keys.push_back(k);
      if (recent_keys.size() > 24) void'(recent_keys.pop_front());
      return k;
   endfunction

   task automatic test_directed_ops();
      send_command(OP_INVALIDATE, 32'd0, 0);
      send_command(OP_INVOKE, 32'hFFFF_FFFF, 0);
      send_command(OP_COMPILE, 32'h0000_0000, 1);
      send_command(OP_COMPILE, 32'h0000_0000, 0);
      send_command(OP_OSR, 32'hFFFF_FFFF, 0);
      send_command(OP_INVOKE, 32'hFFFF_FFFF, 2);
      send_command(OP_OSR, 32'h5555_AAAA, 0);
      send_command(3'd5, 32'hFFFF_FFFF, 0);
      send_command(3'd6, 32'h1234_5678, 0);
      send_command(3'd7, 32'hAAAA_5555, 0);
      send_command(OP_INVALIDATE, 32'hFFFF_FFFF, 0);
      send_command(OP_INVALIDATE, 32'hFFFF_FFFF, 0);
      for (int i = 0; i < 10; i++) send_command(OP_INVOKE, 32'hC0DE_0001, 0);
      send_command(OP_FLUSH, 32'h0000_0000, 0);
   endtask

   task automatic test_threshold_edges();
      write_threshold(8'd0);
      send_command(OP_INVOKE, 32'h0000_0100, 0);
      write_threshold(8'd1);
      send_command(OP_INVOKE, 32'h0000_0101, 0);
      // count up under a high threshold, then lower it below the count
      write_threshold(8'd255);
      for (int i = 0; i < 5; i++) send_command(OP_INVOKE, 32'h0000_0200, 0);
      write_threshold(8'd3);
      send_command(OP_INVOKE, 32'h0000_0200, 0);
      send_command(OP_FLUSH, 32'd0, $urandom_range(0, 6));
   endtask

   // fill the cache and then force lfu evictions
   task automatic test_eviction();
      write_threshold(8'd1);
      for (int i = 0; i < CACHE_ENTRIES; i++)
         send_command(OP_COMPILE, 32'h1000_0000 + i, (i % 8 == 0) ? $urandom_range(0, 6) : 0);
      for (int i = 0; i < 20; i++)
         send_command($urandom_range(0, 1) ? OP_INVOKE : OP_OSR,
                      32'h1000_0000 + $urandom_range(0, 40), 0);
      for (int i = 0; i < 12; i++)
         send_command(i[0] ? OP_INVOKE : OP_COMPILE, 32'h2000_0000 + i, 0);
      send_command(OP_FLUSH, 32'd0, 0);
   endtask

   // every pending slot taken by distinct keys, then a drop
   task automatic test_pending_full();
      write_threshold(8'd200);
      for (int i = 0; i < PENDING_ENTRIES; i++)
         send_command(OP_INVOKE, 32'h3000_0000 + i, 0);
      send_command(OP_INVOKE, 32'h3FFF_FFFF, 0);
      send_command(OP_INVOKE, 32'h3000_0005, 0);
      send_command(OP_COMPILE, 32'h3000_0006, 0);
      send_command(OP_FLUSH, 32'd0, 0);
   endtask

   task automatic test_random_mix();
      int thr_pick;
      logic [2:0] op;
      for (int phase = 0; phase < 4; phase++) begin
         thr_pick = $urandom_range(0, 2);
         write_threshold(thr_pick == 0 ? 8'd2 : thr_pick == 1 ? 8'd4 : 8'($urandom_range(1, 255)));
         for (int n = 0; n < 50; n++) begin
            case ($urandom_range(0, 19))
               0: op = OP_FLUSH;
               1, 2: op = OP_INVALIDATE;
               3, 4, 5: op = OP_COMPILE;
               6, 7: op = OP_OSR;
               8: op = 3'($urandom_range(5, 7));
               default: op = OP_INVOKE;
            endcase
            // stretches without gaps alternate with random gaps
            send_command(op, pick_key(), (n % 20 < 8) ? 0 : $urandom_range(0, 6));
         end
         // hold off until every outstanding response is back
         drain_responses();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_INVOKE;
      req_method_id = '0;
      csr_valid = 1'b0;
      csr_hot_threshold = HOT_THRESHOLD_RESET;
      cycle_count = 0;
      mismatches = 0;
      rsp_seen = 0;
      cmd_sent = 0;
      installs_seen = 0;
      evictions_seen = 0;
      mdl_threshold = HOT_THRESHOLD_RESET;
      clear_tables();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_ops();
      test_threshold_edges();
      test_eviction();
      test_pending_full();
      test_random_mix();
      write_threshold(HOT_THRESHOLD_RESET);
      drain_responses();
      repeat (600) @(negedge clock);

      $display("covered %0d commands, %0d responses, %0d installs, %0d evictions",
               cmd_sent, rsp_seen, installs_seen, evictions_seen);
      $display("threshold settings 0, 1, 255, lowered and random; full cache and full pending table");
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, expected_rsps.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/hmlc_pkg.sv
sv/hmlc_cache_mem.sv
sv/hmlc_pend_mem.sv
sv/hot_method_lfu_cache_top.sv
tb/sv/hot_method_lfu_cache_top_tb.sv
